// ===== rtl/core/skhi_pkg.sv =====
package skhi_pkg;

	// Table, key slot and key byte geometry.
	localparam int TABLE_ENTRIES = 128;
	localparam int KEY_SLOTS     = 64;
	localparam int KEY_BYTES     = 64;
	localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
	localparam int SLOT_AW       = $clog2(KEY_SLOTS);
	localparam int BYTE_AW       = $clog2(KEY_BYTES);
	localparam int LEN_W         = BYTE_AW + 1;
	localparam int CNT_W         = SLOT_AW + 1;

	localparam logic [31:0] HASH_SEED = 32'd5381;
	localparam logic [CNT_W-1:0] MAX_KEYS_RESET = CNT_W'(KEY_SLOTS);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    absorb;
		logic    load_probe;
		logic    probe_next;
		logic    clr_i;
		logic    inc_i;
		logic    set_found;
		logic    set_empty;
		logic    cpy_wr;
		logic    fin_insert;
		logic    emit;
		status_t st;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_byte;
		logic func;
		logic entry_valid;
		logic hash_eq;
		logic len_eq;
		logic len_zero;
		logic byte_eq;
		logic i_last;
		logic probe_end;
		logic found;
		logic have_empty;
		logic full;
	} stat_t;

endpackage

// ===== rtl/core/skhi_ctrl.sv =====
module skhi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  skhi_pkg::stat_t stat,
	output skhi_pkg::cmd_t  cmd
);
	import skhi_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_PRB_RD  = 9'b000000010,
		S_PRB_CHK = 9'b000000100,
		S_LEN_CHK = 9'b000001000,
		S_CMP_RD  = 9'b000010000,
		S_CMP_CHK = 9'b000100000,
		S_DECIDE  = 9'b001000000,
		S_CPY_RD  = 9'b010000000,
		S_CPY_WR  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   fin;

	assign busy = (state_q != S_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.st  = ST_OK;
		fin     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.absorb = 1'b1;
					if (stat.last_byte) begin
						cmd.load_probe = 1'b1;
						state_d        = S_PRB_RD;
					end
				end
			end
			S_PRB_RD: begin
				state_d = S_PRB_CHK;
			end
			S_PRB_CHK: begin
				if (!stat.entry_valid) begin
					cmd.set_empty = 1'b1;
					state_d       = S_DECIDE;
				end else if (stat.hash_eq) begin
					state_d = S_LEN_CHK;
				end else if (stat.probe_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_PRB_RD;
				end
			end
			S_LEN_CHK: begin
				if (stat.len_eq && stat.len_zero) begin
					cmd.set_found = 1'b1;
					state_d       = S_DECIDE;
				end else if (stat.len_eq) begin
					cmd.clr_i = 1'b1;
					state_d   = S_CMP_RD;
				end else if (stat.probe_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_PRB_RD;
				end
			end
			S_CMP_RD: begin
				state_d = S_CMP_CHK;
			end
			S_CMP_CHK: begin
				if (stat.byte_eq && stat.i_last) begin
					cmd.set_found = 1'b1;
					state_d       = S_DECIDE;
				end else if (stat.byte_eq) begin
					cmd.inc_i = 1'b1;
					state_d   = S_CMP_RD;
				end else if (stat.probe_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_PRB_RD;
				end
			end
			S_DECIDE: begin
				if (!stat.func) begin
					cmd.emit = 1'b1;
					cmd.st   = stat.found ? ST_OK : ST_NOT_FOUND;
					state_d  = S_IDLE;
				end else if (stat.found) begin
					cmd.emit = 1'b1;
					cmd.st   = ST_DUPLICATE;
					state_d  = S_IDLE;
				end else if (stat.full || !stat.have_empty) begin
					cmd.emit = 1'b1;
					cmd.st   = ST_FULL;
					state_d  = S_IDLE;
				end else if (stat.len_zero) begin
					fin = 1'b1;
				end else begin
					cmd.clr_i = 1'b1;
					state_d   = S_CPY_RD;
				end
			end
			S_CPY_RD: begin
				state_d = S_CPY_WR;
			end
			S_CPY_WR: begin
				cmd.cpy_wr = 1'b1;
				if (stat.i_last) begin
					fin = 1'b1;
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = S_CPY_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// Commit of an insert: table entry, key length and count.
		if (fin) begin
			cmd.fin_insert = 1'b1;
			cmd.emit       = 1'b1;
			cmd.st         = ST_OK;
			state_d        = S_IDLE;
		end
	end

endmodule

// ===== rtl/core/skhi_dp.sv =====
module skhi_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         func,
	input  logic [7:0]                   key_byte,
	input  logic                         last_byte,
	input  logic                         max_keys_we,
	input  logic [skhi_pkg::CNT_W-1:0]   max_keys_wdata,
	input  skhi_pkg::cmd_t               cmd,
	output skhi_pkg::stat_t              stat,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [skhi_pkg::SLOT_AW-1:0] slot,
	output logic [31:0]                  fold_hash
);
	import skhi_pkg::*;

	// Memories.
	logic [31:0]        entry_hash [TABLE_ENTRIES];
	logic [SLOT_AW-1:0] entry_slot [TABLE_ENTRIES];
	logic [7:0]         key_store  [KEY_SLOTS*KEY_BYTES];
	logic [LEN_W-1:0]   key_length [KEY_SLOTS];
	logic [7:0]         incoming_key [KEY_BYTES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [31:0]        eh_rd;
	logic [SLOT_AW-1:0] es_rd;
	logic               ev_rd;
	logic [7:0]         ks_rd;
	logic [7:0]         ik_rd;
	logic [LEN_W-1:0]   kl_rd;

	// Control registers.
	logic [CNT_W-1:0]   max_keys_q;
	logic [CNT_W-1:0]   key_count_q;
	logic [LEN_W-1:0]   in_len_q;
	logic [31:0]        hash_q;
	logic               key_ended_q;
	logic               func_q;
	logic [TBL_AW-1:0]  idx_q;
	logic [TBL_AW-1:0]  probe_n_q;
	logic [TBL_AW-1:0]  empty_idx_q;
	logic [BYTE_AW-1:0] i_q;
	logic               found_q;
	logic               empty_q;
	logic [SLOT_AW-1:0] found_slot_q;

	logic [7:0]         fold_byte;
	logic [31:0]        next_hash;
	logic [31:0]        next_h;
	logic [31:0]        cur_h;
	logic               take_byte;

	// Case fold and hash step for the incoming byte.
	always_comb begin
		if (key_byte >= 8'h41 && key_byte <= 8'h5A) begin
			fold_byte = key_byte + 8'd32;
		end else begin
			fold_byte = key_byte;
		end
		next_hash = (hash_q << 5) + hash_q + {{24{fold_byte[7]}}, fold_byte};
	end

	assign take_byte = cmd.absorb && !key_ended_q && (key_byte != 8'd0)
		&& (in_len_q < LEN_W'(KEY_BYTES));
	assign next_h = take_byte ? ((next_hash == 32'd0) ? 32'd1 : next_hash)
		: ((hash_q == 32'd0) ? 32'd1 : hash_q);
	assign cur_h  = (hash_q == 32'd0) ? 32'd1 : hash_q;

	// Key accumulation, probe bookkeeping and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_keys_q  <= MAX_KEYS_RESET;
			key_count_q <= '0;
			in_len_q    <= '0;
			hash_q      <= HASH_SEED;
			key_ended_q <= 1'b0;
			found_q     <= 1'b0;
			empty_q     <= 1'b0;
			valid_q     <= '0;
			done        <= 1'b0;
			idx_q       <= '0;
			probe_n_q   <= '0;
			i_q         <= '0;
		end else begin
			if (max_keys_we) begin
				max_keys_q <= max_keys_wdata;
			end
			if (cmd.absorb && !key_ended_q && key_byte == 8'd0) begin
				key_ended_q <= 1'b1;
			end
			if (take_byte) begin
				hash_q   <= next_hash;
				in_len_q <= in_len_q + LEN_W'(1);
			end
			if (cmd.load_probe) begin
				idx_q     <= next_h[TBL_AW-1:0];
				probe_n_q <= '0;
				found_q   <= 1'b0;
				empty_q   <= 1'b0;
			end
			if (cmd.probe_next) begin
				idx_q     <= idx_q + TBL_AW'(1);
				probe_n_q <= probe_n_q + TBL_AW'(1);
			end
			if (cmd.clr_i) begin
				i_q <= '0;
			end
			if (cmd.inc_i) begin
				i_q <= i_q + BYTE_AW'(1);
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.set_empty) begin
				empty_q <= 1'b1;
			end
			if (cmd.fin_insert) begin
				valid_q[empty_idx_q] <= 1'b1;
				key_count_q          <= key_count_q + CNT_W'(1);
			end
			done <= cmd.emit;
			// A delivered result restarts accumulation for the next key.
			if (cmd.emit) begin
				in_len_q    <= '0;
				hash_q      <= HASH_SEED;
				key_ended_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			func_q <= func;
		end
		if (cmd.set_empty) begin
			empty_idx_q <= idx_q;
		end
		if (cmd.set_found) begin
			found_slot_q <= es_rd;
		end
		if (cmd.emit) begin
			status    <= cmd.st;
			fold_hash <= cur_h;
			if (found_q) begin
				slot <= found_slot_q;
			end else if (cmd.fin_insert) begin
				slot <= key_count_q[SLOT_AW-1:0];
			end else begin
				slot <= '0;
			end
		end
	end

	// Table memories, read at the probe index.
	always_ff @(posedge clk) begin
		eh_rd <= entry_hash[idx_q];
		es_rd <= entry_slot[idx_q];
		ev_rd <= valid_q[idx_q];
		if (cmd.fin_insert) begin
			entry_hash[empty_idx_q] <= cur_h;
			entry_slot[empty_idx_q] <= key_count_q[SLOT_AW-1:0];
		end
	end

	// Stored key lengths, read at the slot of the probed entry.
	always_ff @(posedge clk) begin
		kl_rd <= key_length[es_rd];
		if (cmd.fin_insert) begin
			key_length[key_count_q[SLOT_AW-1:0]] <= in_len_q;
		end
	end

	// Stored key bytes.
	always_ff @(posedge clk) begin
		ks_rd <= key_store[{es_rd, i_q}];
		if (cmd.cpy_wr) begin
			key_store[{key_count_q[SLOT_AW-1:0], i_q}] <= ik_rd;
		end
	end

	// Bytes of the key being received.
	always_ff @(posedge clk) begin
		ik_rd <= incoming_key[i_q];
		if (take_byte) begin
			incoming_key[in_len_q[BYTE_AW-1:0]] <= fold_byte;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.last_byte   = last_byte;
		stat.func        = func_q;
		stat.entry_valid = ev_rd;
		stat.hash_eq     = (eh_rd == cur_h);
		stat.len_eq      = (kl_rd == in_len_q);
		stat.len_zero    = (in_len_q == '0);
		stat.byte_eq     = (ks_rd == ik_rd);
		stat.i_last      = ({1'b0, i_q} + LEN_W'(1)) == in_len_q;
		stat.probe_end   = (probe_n_q == TBL_AW'(TABLE_ENTRIES - 1));
		stat.found       = found_q;
		stat.have_empty  = empty_q;
		stat.full        = (key_count_q >= max_keys_q)
			|| (key_count_q >= CNT_W'(KEY_SLOTS));
	end

endmodule

// ===== rtl/core/string_key_hash_index_core.sv =====
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+---------------------------
// key in    | func, key_byte, last_byte              | start high, busy low
// result    | status, slot, fold_hash                | done high for one cycle
// config    | max_keys_wdata                         | max_keys_we high
//
// A byte that is not the last of its key is absorbed while busy stays low.
// The last byte starts a probe of the hash table: each probed entry is read
// and checked, a hash match adds a length check and a read and compare of each
// key byte, a decision state, and on an insert a read and write per key byte.
// The result strobe rises at the same edge at which busy falls.
// The table and key memories are read through registers.
// Reset clears the table valid bits and the key count and loads the hash seed.
// The receiver cannot stall; each result item is shown for exactly one cycle.
module string_key_hash_index_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [7:0]                   key_byte,
	input  logic                         last_byte,
	input  logic                         max_keys_we,
	input  logic [skhi_pkg::CNT_W-1:0]   max_keys_wdata,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [skhi_pkg::SLOT_AW-1:0] slot,
	output logic [31:0]                  fold_hash
);
	import skhi_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	skhi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Hash, memories and result registers.
	skhi_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.func           (func),
		.key_byte       (key_byte),
		.last_byte      (last_byte),
		.max_keys_we    (max_keys_we),
		.max_keys_wdata (max_keys_wdata),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.status         (status),
		.slot           (slot),
		.fold_hash      (fold_hash)
	);

endmodule

// ===== rtl/core/skhi_chk.sv =====
module skhi_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         last_byte,
	input logic                         done,
	input logic [1:0]                   status,
	input logic [skhi_pkg::SLOT_AW-1:0] slot,
	input logic [31:0]                  fold_hash
);
	import skhi_pkg::*;

	// A result only appears once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// A byte that does not end its key is absorbed without a result.
	a_mid_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_byte) |=> (!busy && !done))
		else $error("mid-key byte caused work");

	// The last byte of a key starts the probe.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_byte) |=> busy)
		else $error("last byte did not start probe");

	// The reported hash is never zero.
	a_hash_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (fold_hash != 32'd0)) else $error("zero hash reported");

	// Not found and full carry slot zero.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_NOT_FOUND || status == ST_FULL)) |-> (slot == '0))
		else $error("nonzero slot on miss");

endmodule

bind string_key_hash_index_core skhi_chk u_skhi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.last_byte (last_byte),
	.done      (done),
	.status    (status),
	.slot      (slot),
	.fold_hash (fold_hash)
);

// ===== tb/string_key_hash_index_core_tb.sv =====
module string_key_hash_index_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import skhi_pkg::*;

	// Holds the index state and the queue of results expected from the block.
	class key_index_scoreboard;
		logic [31:0] entry_hash [TABLE_ENTRIES];
		int unsigned entry_slot [TABLE_ENTRIES];
		logic [7:0]  stored_key [KEY_SLOTS][KEY_BYTES];
		int unsigned stored_len [KEY_SLOTS];
		int unsigned key_count;
		int unsigned max_keys;
		logic [7:0]  cur_key [KEY_BYTES];
		int unsigned cur_len;
		logic [31:0] cur_hash;
		bit          cur_ended;
		status_t     exp_status [$];
		logic [5:0]  exp_slot [$];
		logic [31:0] exp_hash [$];
		int          errors;

		function new();
			foreach (entry_hash[i]) begin
				entry_hash[i] = 0;
				entry_slot[i] = 0;
			end
			key_count = 0;
			max_keys = KEY_SLOTS;
			cur_len = 0;
			cur_hash = HASH_SEED;
			cur_ended = 0;
			errors = 0;
		endfunction

		function bit key_matches(int unsigned s);
			if (s >= KEY_SLOTS || stored_len[s] != cur_len)
				return 0;
			for (int i = 0; i < cur_len; i++)
				if (stored_key[s][i] != cur_key[i])
					return 0;
			return 1;
		endfunction

		// Folds one accepted byte into the key and predicts a result on the last byte.
		function void note_item(logic f, logic [7:0] b, logic lst);
			logic [31:0] h;
			logic [31:0] add;
			int unsigned idx, empty_idx, s;
			bit found, have_empty;
			status_t st;
			found = 0;
			have_empty = 0;
			empty_idx = 0;
			s = 0;
			if (!cur_ended) begin
				if (b == 0) begin
					cur_ended = 1;
				end else if (cur_len < KEY_BYTES) begin
					if (b >= 8'h41 && b <= 8'h5A)
						b = b + 8'd32;
					add = {{24{b[7]}}, b};
					cur_hash = (cur_hash << 5) + cur_hash + add;
					cur_key[cur_len] = b;
					cur_len++;
				end
			end
			if (!lst)
				return;
			h = (cur_hash != 0) ? cur_hash : 32'd1;
			idx = h & (TABLE_ENTRIES - 1);
			for (int n = 0; n < TABLE_ENTRIES; n++) begin
				if (entry_hash[idx] == 0) begin
					have_empty = 1;
					empty_idx = idx;
					break;
				end
				if (entry_hash[idx] == h && key_matches(entry_slot[idx])) begin
					found = 1;
					s = entry_slot[idx];
					break;
				end
				idx = (idx + 1) % TABLE_ENTRIES;
			end
			if (f == 0) begin
				st = found ? ST_OK : ST_NOT_FOUND;
			end else if (found) begin
				st = ST_DUPLICATE;
			end else if (key_count >= max_keys || key_count >= KEY_SLOTS || !have_empty) begin
				st = ST_FULL;
			end else begin
				s = key_count;
				for (int i = 0; i < cur_len; i++)
					stored_key[s][i] = cur_key[i];
				stored_len[s] = cur_len;
				entry_hash[empty_idx] = h;
				entry_slot[empty_idx] = s;
				key_count++;
				st = ST_OK;
			end
			exp_status.push_back(st);
			exp_slot.push_back(s[5:0]);
			exp_hash.push_back(h);
			cur_len = 0;
			cur_hash = HASH_SEED;
			cur_ended = 0;
		endfunction

		// Compares one result item with the oldest expectation.
		function void check_result(logic [1:0] st, logic [5:0] sl, logic [31:0] kh);
			status_t es;
			logic [5:0] esl;
			logic [31:0] eh;
			if (exp_status.size() == 0) begin
				$error("unexpected result: status %0d slot %0d hash %h", st, sl, kh);
				errors++;
				return;
			end
			es = exp_status.pop_front();
			esl = exp_slot.pop_front();
			eh = exp_hash.pop_front();
			if (st !== es) begin
				$error("status: expected %0d, actual %0d", es, st);
				errors++;
			end
			if (sl !== esl) begin
				$error("slot: expected %0d, actual %0d", esl, sl);
				errors++;
			end
			if (kh !== eh) begin
				$error("fold_hash: expected %h, actual %h", eh, kh);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, func, last_byte, max_keys_we, done;
	logic [7:0] key_byte;
	logic [CNT_W-1:0] max_keys_wdata;
	logic [1:0] status;
	logic [SLOT_AW-1:0] slot;
	logic [31:0] fold_hash;
	longint cycles = 0;

	key_index_scoreboard board;

	// Pool of keys reused so lookups and duplicates actually hit.
	logic [7:0] key_pool [16][$];

	string_key_hash_index_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.key_byte(key_byte), .last_byte(last_byte), .max_keys_we(max_keys_we),
		.max_keys_wdata(max_keys_wdata), .done(done), .status(status), .slot(slot),
		.fold_hash(fold_hash)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Results are accepted at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(status, slot, fold_hash);
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 50000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Drops start only when a gap follows, so start never gets two updates in one step.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(4, 30));
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Presents one byte and holds it until the block accepts it.
	task automatic send_byte(logic f, logic [7:0] b, logic lst);
		start <= 1;
		func <= f;
		key_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_item(f, b, lst);
		idle_gap();
	endtask

	task automatic send_key(logic f, logic [7:0] k [$]);
		for (int i = 0; i < k.size(); i++)
			send_byte(f, k[i], i == k.size() - 1);
	endtask

	task automatic drain_and_config(int unsigned value);
		start <= 0;
		while (board.exp_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		max_keys_we <= 1;
		max_keys_wdata <= value[CNT_W-1:0];
		@(posedge clk);
		max_keys_we <= 0;
		board.max_keys = value;
		@(posedge clk);
	endtask

	function automatic void make_key(ref logic [7:0] k [$], input int len);
		k.delete();
		for (int i = 0; i < len; i++)
			k.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255)) :
				8'($urandom_range(8'h41, 8'h5A) + ($urandom_range(0, 1) ? 32 : 0)));
	endfunction

	task automatic random_phase(int count);
		logic [7:0] k [$];
		int p;
		for (int n = 0; n < count; n++) begin
			p = $urandom_range(0, 15);
			case ($urandom_range(0, 9))
				0: begin
					make_key(k, $urandom_range(1, 8));
					k.insert($urandom_range(0, k.size() - 1), 8'h00);
					send_key(1'($urandom_range(0, 1)), k);
				end
				1: begin
					make_key(k, $urandom_range(60, 70));
					send_key(1'($urandom_range(0, 1)), k);
				end
				2, 3, 4: begin
					// Mixed-case copy of a pooled key.
					k = key_pool[p];
					foreach (k[i])
						if ($urandom_range(0, 1) && ((k[i] | 8'h20) >= 8'h61) &&
							((k[i] | 8'h20) <= 8'h7A))
							k[i] = k[i] ^ 8'h20;
					send_key(1'b0, k);
				end
				5, 6: send_key(1'b1, key_pool[p]);
				default: begin
					make_key(k, $urandom_range(1, 6));
					send_key(1'($urandom_range(0, 1)), k);
				end
			endcase
		end
	endtask

	initial begin
		logic [7:0] k [$];
		board = new();
		arst_n = 0;
		start = 0;
		func = 0;
		key_byte = 0;
		last_byte = 0;
		max_keys_we = 0;
		max_keys_wdata = 0;
		for (int i = 0; i < 16; i++)
			make_key(key_pool[i], $urandom_range(1, 10));
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, zero byte, long key, case folding, duplicates.
		drain_and_config(2);
		k = {8'hFF};
		send_key(1'b0, k);
		send_key(1'b1, k);
		send_key(1'b1, k);
		k = {8'h80, 8'h7F, 8'h01};
		send_key(1'b1, k);
		k = {8'h41, 8'h5A};
		send_key(1'b1, k);
		send_key(1'b1, {8'h61, 8'h7A});
		send_key(1'b0, {8'h61, 8'h7A});
		send_key(1'b0, {8'h00});
		send_key(1'b1, {8'h62, 8'h00, 8'h63, 8'hFF});
		make_key(k, 70);
		send_key(1'b1, k);
		drain_and_config(0);
		send_key(1'b1, {8'h55, 8'hAA});
		send_key(1'b0, {8'h80, 8'h7F, 8'h01});

		// Random phases under several limits, the extremes among them.
		drain_and_config(64);
		random_phase(8);
		drain_and_config(127);
		random_phase(6);
		drain_and_config(5);
		random_phase(6);
		drain_and_config(64);
		// One-byte keys until the key store fills.
		for (int i = 0; i < 70; i++) begin
			k = {8'(i + 1)};
			send_key(1'b1, k);
		end
		random_phase(4);

		start <= 0;
		while (board.exp_status.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
